@@ rtl/core/cdte_pkg.sv @@
// ----------------------------------------------------------------------------
// cdte_pkg: shared types and constants for the civil date to epoch converter
// Stage payload structs, status codes, and the month offset table.
// ----------------------------------------------------------------------------
package cdte_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NARROW = 2'd2
  } status_t;

  localparam int YEAR_BASE = 1900;
  // floor(q/25) = floor((q + DIV_BIAS)/25) - 2^23, keeps the dividend unsigned
  localparam int DIV_BIAS  = 25 * (2 ** 23);
  // ceil(2^34 / 25); exact for dividends below 2^29
  localparam longint DIV_RECIP = 64'd687194768;
  localparam int DIV_SHIFT = 34;
  localparam int ERA_DAYS  = 146097;
  localparam int EPOCH_OFS = 719468;
  localparam int DAY_SCALE = 675;  // 86400 = 675 << 7

  // after field check, year shifted to a March-based year
  typedef struct packed {
    logic              err;
    logic signed [32:0] yr;
    logic [8:0]        doy;
    logic [16:0]       tod;
  } front_t;

  typedef struct packed {
    logic              err;
    logic signed [23:0] era;
    logic [8:0]        yoe;
    logic [8:0]        doy;
    logic [16:0]       tod;
  } era_t;

  typedef struct packed {
    logic              err;
    logic signed [41:0] days;
    logic [16:0]       tod;
  } days_t;

  // days from March 1 to the first of the given month (month 0 = January)
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/cdte_front.sv @@
// ----------------------------------------------------------------------------
// cdte_front: field range check and first pipeline stage
// Flags bad fields, shifts the year to a March start, forms day of year and
// seconds of day.
// ----------------------------------------------------------------------------
module cdte_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] year_since_1900,
  input  logic [3:0]         month_index,
  input  logic [5:0]         day_of_month,
  input  logic [4:0]         hour_value,
  input  logic [5:0]         minute_value,
  input  logic [5:0]         second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output cdte_pkg::front_t   out_data
);
  import cdte_pkg::*;

  logic   valid;
  front_t data;
  front_t data_next;
  logic   adv;

  assign adv      = !valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic jan_feb;
    jan_feb = (month_index <= 4'd1);
    data_next.err = (month_index > 4'd11) || (day_of_month == 6'd0) ||
                    (day_of_month > 6'd31) || (hour_value > 5'd23) ||
                    (minute_value > 6'd59) || (second_value > 6'd60);
    data_next.yr  = {year_since_1900[31], year_since_1900} + 33'(YEAR_BASE)
                    - (jan_feb ? 33'sd1 : 33'sd0);
    data_next.doy = days_before(month_index) + {3'b0, day_of_month} - 9'd1;
    data_next.tod = 17'(hour_value) * 17'd3600 + 17'(minute_value) * 17'd60
                    + 17'(second_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

@@ rtl/core/cdte_era.sv @@
// ----------------------------------------------------------------------------
// cdte_era: 400-year era split
// Two stages: reciprocal multiply for floor(yr/400), then era and year of era.
// ----------------------------------------------------------------------------
module cdte_era (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdte_pkg::front_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cdte_pkg::era_t   out_data
);
  import cdte_pkg::*;

  logic        v1;
  logic        v2;
  logic        adv1;
  logic        adv2;
  logic        err1;
  logic [8:0]  yr_lo;
  logic [8:0]  doy1;
  logic [16:0] tod1;
  logic [58:0] prod;
  logic [58:0] prod_next;
  era_t        data;
  era_t        data_next;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // floor(yr/400) = floor(floor(yr/16)/25), biased so the divide is unsigned
  always_comb begin
    logic signed [29:0] u_wide;
    u_wide    = {in_data.yr[32], in_data.yr[32:4]} + 30'(DIV_BIAS);
    prod_next = 59'(u_wide[28:0]) * 59'(DIV_RECIP);
  end

  always_comb begin
    logic [24:0] era_u;
    logic [24:0] era_w;
    era_u          = prod[58:DIV_SHIFT];
    era_w          = era_u - 25'(2 ** 23);
    data_next.err  = err1;
    data_next.era  = era_w[23:0];
    // yoe is in 0..399, so nine low bits settle it
    data_next.yoe  = yr_lo - 9'(era_w[8:0] * 9'd400);
    data_next.doy  = doy1;
    data_next.tod  = tod1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod  <= prod_next;
      err1  <= in_data.err;
      yr_lo <= in_data.yr[8:0];
      doy1  <= in_data.doy;
      tod1  <= in_data.tod;
    end
    if (adv2 && v1) begin
      data <= data_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = data;

endmodule

@@ rtl/core/cdte_days.sv @@
// ----------------------------------------------------------------------------
// cdte_days: day count since 1970-01-01
// Stage one: day of era and era term. Stage two: sum with the epoch offset.
// ----------------------------------------------------------------------------
module cdte_days (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdte_pkg::era_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cdte_pkg::days_t out_data
);
  import cdte_pkg::*;

  logic               v1;
  logic               v2;
  logic               adv1;
  logic               adv2;
  logic               err1;
  logic [16:0]        tod1;
  logic [17:0]        doe;
  logic [17:0]        doe_next;
  logic signed [41:0] eterm;
  logic signed [41:0] eterm_next;
  days_t              data;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    logic [1:0] cent;
    if (in_data.yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (in_data.yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (in_data.yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doe_next   = 18'(in_data.yoe) * 18'd365 + 18'(in_data.yoe[8:2]) - 18'(cent)
                 + 18'(in_data.doy);
    eterm_next = in_data.era * 42'(ERA_DAYS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      doe   <= doe_next;
      eterm <= eterm_next;
      err1  <= in_data.err;
      tod1  <= in_data.tod;
    end
    if (adv2 && v1) begin
      data.err  <= err1;
      data.days <= eterm + $signed({24'b0, doe}) - 42'(EPOCH_OFS);
      data.tod  <= tod1;
    end
  end

  assign out_valid = v2;
  assign out_data  = data;

endmodule

@@ rtl/core/cdte_scale.sv @@
// ----------------------------------------------------------------------------
// cdte_scale: days to seconds and result register
// Multiply by 675, shift by 7, add time of day, then status and output.
// ----------------------------------------------------------------------------
module cdte_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               narrow_time,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdte_pkg::days_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] epoch_seconds
);
  import cdte_pkg::*;

  logic               v1;
  logic               v2;
  logic               v3;
  logic               adv1;
  logic               adv2;
  logic               adv3;
  logic               err1;
  logic               err2;
  logic [16:0]        tod1;
  logic signed [52:0] prod;
  logic signed [63:0] secs;
  logic               wide;
  status_t            st;
  logic signed [63:0] res;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // fits signed 32 bits when the top 33 bits agree
  assign wide = !((secs[63:31] == '0) || (secs[63:31] == '1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod <= in_data.days * 53'(DAY_SCALE);
      err1 <= in_data.err;
      tod1 <= in_data.tod;
    end
    if (adv2 && v1) begin
      secs <= {{4{prod[52]}}, prod, 7'b0} + $signed({47'b0, tod1});
      err2 <= err1;
    end
    if (adv3 && v2) begin
      if (err2) begin
        st  <= ST_RANGE;
        res <= '0;
      end else if (narrow_time && wide) begin
        st  <= ST_NARROW;
        res <= '0;
      end else begin
        st  <= ST_OK;
        res <= secs;
      end
    end
  end

  assign out_valid     = v3;
  assign status        = st;
  assign epoch_seconds = res;

endmodule

@@ rtl/core/civil_date_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// civil_date_to_epoch_seconds: broken-down UTC time to signed epoch seconds
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   year, month, day, h, m, s
//   out      output     out_valid / out_ready status, epoch_seconds
//   cfg      input      cfg_write             cfg_data[0] -> narrow_time
//
// Eight register stages; one beat accepted per cycle unless out_ready
// stalls the chain. In order: field check, era multiply, era split,
// day of era and era term, day sum, day scale multiply, seconds add,
// result register.
// Synchronous reset clears valid bits and narrow_time; payload is not reset.
// A stall holds each full stage; empty stages still fill, so bubbles close.
// ----------------------------------------------------------------------------
module civil_date_to_epoch_seconds (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] year_since_1900,
  input  logic [3:0]         month_index,
  input  logic [5:0]         day_of_month,
  input  logic [4:0]         hour_value,
  input  logic [5:0]         minute_value,
  input  logic [5:0]         second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] epoch_seconds
);
  import cdte_pkg::*;

  logic   narrow_time;
  logic   f_valid;
  logic   f_ready;
  front_t f_data;
  logic   e_valid;
  logic   e_ready;
  era_t   e_data;
  logic   d_valid;
  logic   d_ready;
  days_t  d_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_time <= 1'b0;
    end else if (cfg_write) begin
      narrow_time <= cfg_data;
    end
  end

  cdte_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .year_since_1900 (year_since_1900),
    .month_index     (month_index),
    .day_of_month    (day_of_month),
    .hour_value      (hour_value),
    .minute_value    (minute_value),
    .second_value    (second_value),
    .out_valid       (f_valid),
    .out_ready       (f_ready),
    .out_data        (f_data)
  );

  cdte_era u_era (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_data  (e_data)
  );

  cdte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_data   (e_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  cdte_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .narrow_time   (narrow_time),
    .in_valid      (d_valid),
    .in_ready      (d_ready),
    .in_data       (d_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .epoch_seconds (epoch_seconds)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> epoch_seconds == '0)
    else $error("nonzero seconds with error status");

  a_narrow_fit: assert property (@(posedge clk) disable iff (rst)
    out_valid && narrow_time && (status == ST_OK)
      |-> (epoch_seconds[63:31] == '0) || (epoch_seconds[63:31] == '1))
    else $error("narrow result does not fit 32 bits");

  a_narrow_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !narrow_time |-> status != ST_NARROW)
    else $error("narrow status while narrow_time clear");
`endif

endmodule
